>>> rtl/core/vpts_pkg.sv
package vpts_pkg;

  localparam int VPTS_COORD_WIDTH = 32;
  localparam int VPTS_COEF_WIDTH  = 16;

  localparam int COEF_FRAC   = 12;  // Q4.12 coefficients
  localparam int FRAC_BITS   = 16;  // Q.16 coordinates
  localparam int LANE_STRIDE = 16;  // coefficient lane pitch in a matrix register
  localparam int NUM_LANES   = 4;

  localparam int ONE_Q12 = 4096;
  localparam int ONE_Q16 = 65536;

  // half screen size, truncated: 16-bit size >> 1
  localparam int HALF_W          = 15;
  localparam logic [HALF_W-1:0] HALF_W_RST = 15'd640;
  localparam logic [HALF_W-1:0] HALF_H_RST = 15'd360;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COL_X  = 3'd0,
    CFG_COL_Y  = 3'd1,
    CFG_COL_Z  = 3'd2,
    CFG_COL_W  = 3'd3,
    CFG_SCR_W  = 3'd4,
    CFG_SCR_H  = 3'd5
  } cfg_idx_e;

endpackage

>>> rtl/core/vpts_front.sv
module vpts_front import vpts_pkg::*; #(
  parameter int CW  = VPTS_COORD_WIDTH,
  parameter int CEW = VPTS_COEF_WIDTH
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic signed [CW-1:0]                       pos_x_i,
  input  logic signed [CW-1:0]                       pos_y_i,
  input  logic signed [CW-1:0]                       pos_z_i,
  input  logic [NUM_LANES-1:0][NUM_LANES-1:0][CEW-1:0] coef_i,
  input  logic                                       full_i,
  output logic                                       push_o,
  output logic [4*(CW+CEW-10):0]                     entry_o
);

  localparam int PW     = CW + CEW;
  localparam int TW     = PW - COEF_FRAC;
  localparam int CLIP_W = CW + CEW - 10;

  logic signed [CW-1:0]     pos [3];
  logic signed [TW-1:0]     term_d [NUM_LANES][3];
  logic signed [TW-1:0]     term_q [NUM_LANES][3];
  logic signed [CLIP_W-1:0] clip_d [NUM_LANES];
  logic signed [CLIP_W-1:0] clip_q [NUM_LANES];
  logic                     s1_valid_q, s2_valid_q;
  logic                     en;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  // whole front moves unless the sum stage holds an item the queue cannot take
  assign en         = !s2_valid_q || !full_i;
  assign in_ready_o = en;
  assign push_o     = s2_valid_q && !full_i;

  // product rounded toward minus infinity: drop the low fraction bits
  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      for (int l = 0; l < 3; l++) begin
        logic signed [PW-1:0] prod;
        prod         = pos[l] * $signed(coef_i[c][l]);
        term_d[c][l] = prod[PW-1:COEF_FRAC];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      clip_d[c] = CLIP_W'(term_q[c][0]) + CLIP_W'(term_q[c][1]) + CLIP_W'(term_q[c][2])
                + (CLIP_W'($signed(coef_i[c][3])) <<< (FRAC_BITS - COEF_FRAC));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      term_q <= term_d;
      clip_q <= clip_d;
    end
  end

  assign entry_o = {(clip_q[3] == '0), clip_q[3], clip_q[2], clip_q[1], clip_q[0]};

endmodule

>>> rtl/core/vpts_fifo.sv
module vpts_fifo import vpts_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    cnt_q;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/vpts_div.sv
module vpts_div import vpts_pkg::*; #(
  parameter int CLIP_W = 38,
  parameter int CW     = VPTS_COORD_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CLIP_W-1:0] num_i,
  input  logic signed [CLIP_W-1:0] den_i,
  output logic signed [CW+2:0]     quot_o
);

  // restoring division, one quotient bit per stage; quotient shifts in
  // behind the dividend bits it consumes
  localparam int DW = CLIP_W + FRAC_BITS;
  localparam int MW = CW + 2;

  logic [DW-1:0]     dq_q  [DW+1];
  logic [CLIP_W-1:0] rem_q [DW+1];
  logic [CLIP_W-1:0] den_q [DW+1];
  logic              neg_q [DW+1];
  logic [CLIP_W-1:0] ua, ub;
  logic [DW-1:0]     q;
  logic              ovf;
  logic [MW-1:0]     mag;
  logic signed [CW+2:0] quot_q;

  assign ua = num_i[CLIP_W-1] ? (~num_i + 1'b1) : num_i;
  assign ub = den_i[CLIP_W-1] ? (~den_i + 1'b1) : den_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dq_q[0]  <= {ua, {FRAC_BITS{1'b0}}};
      rem_q[0] <= '0;
      den_q[0] <= ub;
      neg_q[0] <= num_i[CLIP_W-1] ^ den_i[CLIP_W-1];
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_step
    logic [CLIP_W:0] pre, sub;
    logic            ge;
    assign pre = {rem_q[k-1], dq_q[k-1][DW-1]};
    assign ge  = (pre >= {1'b0, den_q[k-1]});
    assign sub = ge ? (pre - {1'b0, den_q[k-1]}) : pre;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dq_q[k]  <= {dq_q[k-1][DW-2:0], ge};
        rem_q[k] <= sub[CLIP_W-1:0];
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // cap at 2^(CW+1) in Q.16: beyond every output limit
  assign q   = dq_q[DW];
  assign ovf = (|q[DW-1:MW]) || (q[MW-1] && (|q[MW-2:0]));
  assign mag = ovf ? {1'b1, {(MW-1){1'b0}}} : q[MW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= neg_q[DW] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign quot_o = quot_q;

endmodule

>>> rtl/core/vpts_back.sv
module vpts_back import vpts_pkg::*; #(
  parameter int CW  = VPTS_COORD_WIDTH,
  parameter int CEW = VPTS_COEF_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [4*(CW+CEW-10):0]     entry_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  input  logic [HALF_W-1:0]          half_w_i,
  input  logic [HALF_W-1:0]          half_h_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [CW-1:0]       screen_x_o,
  output logic signed [CW-1:0]       screen_y_o,
  output logic signed [CW-1:0]       depth_o,
  output logic                       visible_o,
  output logic                       w_zero_o
);

  localparam int CLIP_W = CW + CEW - 10;
  localparam int QW     = CW + 3;
  localparam int PRW    = QW + HALF_W + 1;
  localparam int SW     = PRW + 2;
  localparam int LD     = CLIP_W + FRAC_BITS + 2;  // divider latency
  localparam int NV     = LD + 1;

  localparam logic signed [QW-1:0] ONE_N  = QW'(ONE_Q16);
  localparam logic signed [QW-1:0] MONE_N = -ONE_N;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
    logic signed [CW-1:0] r;
    r = v[CW-1:0];
    if (v > SAT_HI) r = SAT_HI[CW-1:0];
    else if (v < SAT_LO) r = SAT_LO[CW-1:0];
    return r;
  endfunction

  logic                     en;
  logic signed [CLIP_W-1:0] cx, cy, cz, cw;
  logic signed [QW-1:0]     nx, ny, nz;
  logic                     vld_q [NV];
  logic                     wz_q  [NV];
  logic signed [PRW-1:0]    prod_x_q, prod_y_q;
  logic signed [QW-1:0]     nz_q;
  logic                     vis_q;
  logic signed [SW-1:0]     hw_q16, hh_q16, sum_x, sum_y;
  logic                     out_valid_q;

  // single stall for the whole back end, released by the output register
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !empty_i;

  assign cx = entry_i[0*CLIP_W +: CLIP_W];
  assign cy = entry_i[1*CLIP_W +: CLIP_W];
  assign cz = entry_i[2*CLIP_W +: CLIP_W];
  assign cw = entry_i[3*CLIP_W +: CLIP_W];

  vpts_div #(.CLIP_W(CLIP_W), .CW(CW)) u_div_x (
    .clk_i, .en_i(en), .num_i(cx), .den_i(cw), .quot_o(nx)
  );
  vpts_div #(.CLIP_W(CLIP_W), .CW(CW)) u_div_y (
    .clk_i, .en_i(en), .num_i(cy), .den_i(cw), .quot_o(ny)
  );
  vpts_div #(.CLIP_W(CLIP_W), .CW(CW)) u_div_z (
    .clk_i, .en_i(en), .num_i(cz), .den_i(cw), .quot_o(nz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) vld_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= !empty_i;
      for (int i = 1; i < NV; i++) vld_q[i] <= vld_q[i-1];
      out_valid_q <= vld_q[NV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wz_q[0] <= entry_i[4*CLIP_W];
      for (int i = 1; i < NV; i++) wz_q[i] <= wz_q[i-1];
    end
  end

  // viewport scale and visibility
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q <= nx * $signed({1'b0, half_w_i});
      prod_y_q <= ny * $signed({1'b0, half_h_i});
      nz_q     <= nz;
      vis_q    <= (nx >= MONE_N) && (nx <= ONE_N) && (ny >= MONE_N) && (ny <= ONE_N)
               && !nz[QW-1];
    end
  end

  assign hw_q16 = $signed(SW'({half_w_i, {FRAC_BITS{1'b0}}}));
  assign hh_q16 = $signed(SW'({half_h_i, {FRAC_BITS{1'b0}}}));
  assign sum_x  = SW'(prod_x_q) + hw_q16;
  assign sum_y  = hh_q16 - SW'(prod_y_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (wz_q[NV-1]) begin
        screen_x_o <= '0;
        screen_y_o <= '0;
        depth_o    <= '0;
        visible_o  <= 1'b0;
        w_zero_o   <= 1'b1;
      end else begin
        screen_x_o <= sat_cw(sum_x);
        screen_y_o <= sat_cw(sum_y);
        depth_o    <= sat_cw(SW'(nz_q));
        visible_o  <= vis_q;
        w_zero_o   <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/vertex_project_to_screen_unit.sv
// Vertex projection unit: each transaction carries one Q16.16 point, is
// transformed by the configured 4x4 Q4.12 matrix, divided by w and mapped to
// screen pixels. One point per clock is sustained while out_ready_i is high;
// most of the pipeline is the divider, which resolves one quotient bit per
// pipeline stage over COORD_WIDTH + COEF_WIDTH + 6 stages. The front (two
// stages: products, sums and w-zero check) feeds a 4-entry queue; the back
// (three parallel dividers, scale stage, output register) stalls as a whole
// on out_ready_i while the front keeps accepting until the queue fills.
// Configuration writes (index 0..3 matrix columns x,y,z,w, 4 width, 5 height,
// higher indexes ignored) take effect at once and are expected only when idle.
module vertex_project_to_screen_unit import vpts_pkg::*; #(
  parameter int COORD_WIDTH = VPTS_COORD_WIDTH,
  parameter int COEF_WIDTH  = VPTS_COEF_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  // point input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  // screen result
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] screen_x_o,
  output logic signed [COORD_WIDTH-1:0] screen_y_o,
  output logic signed [COORD_WIDTH-1:0] depth_o,
  output logic                          visible_o,
  output logic                          w_zero_o
);

  localparam int CLIP_W = COORD_WIDTH + COEF_WIDTH - 10;
  localparam int EW     = 4 * CLIP_W + 1;  // x,y,z,w clip values plus w-zero flag

  // coef_q[column][lane], lanes weight x, y, z and the constant 1
  logic [NUM_LANES-1:0][NUM_LANES-1:0][COEF_WIDTH-1:0] coef_q;
  logic [HALF_W-1:0] half_w_q, half_h_q;

  logic          push, full, pop, empty;
  logic [EW-1:0] entry_in, entry_out;

  // Config registers. Screen sizes are kept as their truncated halves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          coef_q[c][l] <= (c == l) ? COEF_WIDTH'(ONE_Q12) : '0;
        end
      end
      half_w_q <= HALF_W_RST;
      half_h_q <= HALF_H_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COL_X, CFG_COL_Y, CFG_COL_Z, CFG_COL_W: begin
          for (int l = 0; l < NUM_LANES; l++) begin
            coef_q[cfg_idx_i[1:0]][l] <= cfg_wdata_i[LANE_STRIDE*l +: COEF_WIDTH];
          end
        end
        CFG_SCR_W: half_w_q <= cfg_wdata_i[HALF_W:1];
        CFG_SCR_H: half_h_q <= cfg_wdata_i[HALF_W:1];
        default: ;
      endcase
    end
  end

  // front: matrix transform
  vpts_front #(.CW(COORD_WIDTH), .CEW(COEF_WIDTH)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .pos_x_i,
    .pos_y_i,
    .pos_z_i,
    .coef_i  (coef_q),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry_in)
  );

  // decoupling queue
  vpts_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (entry_out),
    .empty_o (empty)
  );

  // back: divide, viewport map, saturate
  vpts_back #(.CW(COORD_WIDTH), .CEW(COEF_WIDTH)) u_back (
    .clk_i,
    .rst_ni,
    .entry_i  (entry_out),
    .empty_i  (empty),
    .pop_o    (pop),
    .half_w_i (half_w_q),
    .half_h_i (half_h_q),
    .out_ready_i,
    .out_valid_o,
    .screen_x_o,
    .screen_y_o,
    .depth_o,
    .visible_o,
    .w_zero_o
  );

  // a w-zero result carries no geometry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && w_zero_o |->
      !visible_o && screen_x_o == '0 && screen_y_o == '0 && depth_o == '0)
    else $error("w-zero result with nonzero fields");

  // inside [-1,1] with nonnegative depth maps to nonnegative pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && visible_o |->
      !depth_o[COORD_WIDTH-1] && !screen_x_o[COORD_WIDTH-1] && !screen_y_o[COORD_WIDTH-1])
    else $error("visible result with negative coordinate");

  // the back end only drains the queue when it holds something
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule
